// File: hdl/json_syntax_validator_core_defines.svh
`ifndef JSON_SYNTAX_VALIDATOR_CORE_DEFINES_SVH
`define JSON_SYNTAX_VALIDATOR_CORE_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define JSV_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("json validator check failed");

// next-cycle implication
`define JSV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("json validator check failed");

`endif

// File: hdl/jsv_pkg.sv
package jsv_pkg;

  localparam int unsigned StackEntries = 64;
  localparam logic [5:0]  MaxDepthRst  = 6'd32;

  localparam logic [1:0] StatBusy   = 2'd0;
  localparam logic [1:0] StatAccept = 2'd1;
  localparam logic [1:0] StatReject = 2'd2;

  localparam logic [1:0] WordTrue  = 2'd0;
  localparam logic [1:0] WordFalse = 2'd1;
  localparam logic [1:0] WordNull  = 2'd2;

  localparam logic KindArr = 1'b0;
  localparam logic KindObj = 1'b1;

  localparam logic RegMaxDepth = 1'b0;

  typedef enum logic [22:0] {
    ST_TOP_VALUE   = 23'h000001,
    ST_TOP_DONE    = 23'h000002,
    ST_ARR_FIRST   = 23'h000004,
    ST_ARR_VALUE   = 23'h000008,
    ST_OBJ_FIRST   = 23'h000010,
    ST_OBJ_KEY     = 23'h000020,
    ST_OBJ_COLON   = 23'h000040,
    ST_OBJ_VALUE   = 23'h000080,
    ST_AFTER_VALUE = 23'h000100,
    ST_STR_CHAR    = 23'h000200,
    ST_STR_ESC     = 23'h000400,
    ST_STR_HEX     = 23'h000800,
    ST_STR_SUR_BS  = 23'h001000,
    ST_STR_SUR_U   = 23'h002000,
    ST_NUM_MINUS   = 23'h004000,
    ST_NUM_ZERO    = 23'h008000,
    ST_NUM_INT     = 23'h010000,
    ST_NUM_DOT     = 23'h020000,
    ST_NUM_FRAC    = 23'h040000,
    ST_NUM_EXP     = 23'h080000,
    ST_NUM_EXP_SGN = 23'h100000,
    ST_NUM_EXP_DIG = 23'h200000,
    ST_LITERAL     = 23'h400000
  } state_e;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
    logic kind;
  } stk_ctrl_t;

  function automatic logic [7:0] lit_char(input logic [1:0] word, input logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    case (word)
      WordTrue: begin
        case (idx)
          3'd1: ch = "r";
          3'd2: ch = "u";
          3'd3: ch = "e";
          default: ch = 8'h00;
        endcase
      end
      WordFalse: begin
        case (idx)
          3'd1: ch = "a";
          3'd2: ch = "l";
          3'd3: ch = "s";
          3'd4: ch = "e";
          default: ch = 8'h00;
        endcase
      end
      WordNull: begin
        case (idx)
          3'd1: ch = "u";
          3'd2: ch = "l";
          3'd3: ch = "l";
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] word);
    return (word == WordFalse) ? 3'd5 : 3'd4;
  endfunction

endpackage

// File: hdl/jsv_ram.sv
module jsv_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hdl/jsv_stack.sv
// Nesting stack: top two entries in flops, the rest in a RAM. The entry under
// the second one is prefetched every cycle so a pop has it ready.
module jsv_stack #(
  parameter int unsigned StackEntries = jsv_pkg::StackEntries
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  jsv_pkg::stk_ctrl_t                ctrl_i,
  output logic                              tos_o,
  output logic [$clog2(StackEntries+1)-1:0] depth_o
);

  localparam int unsigned DW = $clog2(StackEntries + 1);
  localparam int unsigned AW = $clog2(StackEntries);

  logic [DW-1:0] depth_q, depth_d;
  logic          tos_q, tos_d, nos_q, nos_d;
  logic          fwd_q, fwd_d, fwd_bit_q;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic          ram_rd, below;

  assign we    = en_i && ctrl_i.push && !ctrl_i.clear && (depth_q >= DW'(2));
  assign waddr = AW'(depth_q - DW'(2));
  assign raddr = AW'(depth_d - DW'(3));
  assign below = fwd_q ? fwd_bit_q : ram_rd;
  assign fwd_d = we && (waddr == raddr);

  always_comb begin
    depth_d = depth_q;
    tos_d   = tos_q;
    nos_d   = nos_q;
    if (en_i) begin
      if (ctrl_i.clear) begin
        depth_d = '0;
      end else if (ctrl_i.push) begin
        depth_d = depth_q + DW'(1);
        nos_d   = tos_q;
        tos_d   = ctrl_i.kind;
      end else if (ctrl_i.pop) begin
        depth_d = depth_q - DW'(1);
        tos_d   = nos_q;
        nos_d   = below;
      end
    end
  end

  jsv_ram #(.Width(1), .Depth(StackEntries)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (nos_q),
    .raddr_i (raddr),
    .rdata_o (ram_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      fwd_q   <= 1'b0;
    end else begin
      depth_q <= depth_d;
      fwd_q   <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tos_q     <= tos_d;
    nos_q     <= nos_d;
    fwd_bit_q <= nos_q;
  end

  assign tos_o   = tos_q;
  assign depth_o = depth_q;

endmodule

// File: hdl/json_syntax_validator_core.sv
// Strict JSON text checker, one byte per item.
// Input stream: s_axis_tdata_i carries a text byte, s_axis_tlast_i marks the
// final byte of a text. Every accepted byte yields exactly one result item on
// the master side: status (0 busy, 1 accepted, 2 rejected) and the count of
// open containers after that byte.
// The result for a byte is registered and presented in the cycle after acceptance.
// Throughput: one byte per cycle unless the receiver stalls; grammar state
// sits in flops and the nesting stack in a one-port-write / one-port-read
// RAM whose next entry is prefetched each cycle, so pops never wait.
// When the receiver stalls, the registered result holds and s_axis_tready_o
// drops until the result is taken; a result taken in the same cycle frees
// the slot for the next byte.
// Reset clears grammar state, stack depth and sets max_depth to 32; no RAM
// clearing pass is needed. After the last byte of a text the block returns
// to its reset grammar state. The user must write max_depth over the APB port
// at address 0 while the block is idle; the block does not enforce this.
module json_syntax_validator_core #(
  parameter int unsigned StackEntries = jsv_pkg::StackEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] text_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [1:0] status, [8:2] nesting, rest zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned DW = $clog2(StackEntries + 1);

  jsv_pkg::state_e    state_q, state_d, eff;
  jsv_pkg::stk_ctrl_t ctrl;
  logic [5:0]    max_depth_q;
  logic          failed_q, failed_d, key_q, key_d, sur_q, sur_d;
  logic [2:0]    hex_q, hex_d, lidx_q, lidx_d;
  logic [1:0]    word_q, word_d;
  logic [15:0]   code_q, code_d, code_n;
  logic          out_valid_q;
  logic [1:0]    out_stat_q, stat;
  logic [6:0]    out_nest_q;
  logic          in_fire, tos, ok, consumed, done;
  logic [DW-1:0] depth, depth_nx;
  logic [7:0]    c;
  logic          is_ws, is_dig, hex_ok;
  logic [3:0]    hex_v;
  jsv_pkg::state_e vdone, cdone;
  // start of a value
  logic          sv_ok, sv_push, sv_kind;
  jsv_pkg::state_e sv_state;
  logic [1:0]    sv_word;

  assign pready = 1'b1;
  assign prdata = {26'd0, max_depth_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_depth_q <= jsv_pkg::MaxDepthRst;
    end else if (psel && penable && pwrite && (paddr[2] == jsv_pkg::RegMaxDepth)) begin
      max_depth_q <= pwdata[5:0];
    end
  end

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign c = s_axis_tdata_i;

  assign is_ws  = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
  assign is_dig = (c >= "0") && (c <= "9");

  always_comb begin
    hex_ok = 1'b1;
    hex_v  = 4'd0;
    if (is_dig) begin
      hex_v = 4'(c - "0");
    end else if ((c >= "a") && (c <= "f")) begin
      hex_v = 4'(c - "a" + 8'd10);
    end else if ((c >= "A") && (c <= "F")) begin
      hex_v = 4'(c - "A" + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end
  assign code_n = {code_q[11:0], hex_v};

  assign vdone = (depth == '0) ? jsv_pkg::ST_TOP_DONE : jsv_pkg::ST_AFTER_VALUE;
  assign cdone = (depth == DW'(1)) ? jsv_pkg::ST_TOP_DONE : jsv_pkg::ST_AFTER_VALUE;

  always_comb begin
    sv_ok    = 1'b1;
    sv_push  = 1'b0;
    sv_kind  = jsv_pkg::KindArr;
    sv_state = jsv_pkg::ST_NUM_INT;
    sv_word  = jsv_pkg::WordTrue;
    if (32'(depth) > 32'(max_depth_q)) begin
      sv_ok = 1'b0;
    end else if ((c == "{") || (c == "[")) begin
      sv_kind  = (c == "{") ? jsv_pkg::KindObj : jsv_pkg::KindArr;
      sv_state = (c == "{") ? jsv_pkg::ST_OBJ_FIRST : jsv_pkg::ST_ARR_FIRST;
      sv_push  = 1'b1;
      sv_ok    = 32'(depth) < StackEntries;
    end else if (c == "\"") begin
      sv_state = jsv_pkg::ST_STR_CHAR;
    end else if ((c == "t") || (c == "f") || (c == "n")) begin
      sv_state = jsv_pkg::ST_LITERAL;
      sv_word  = (c == "t") ? jsv_pkg::WordTrue :
                 (c == "f") ? jsv_pkg::WordFalse : jsv_pkg::WordNull;
    end else if (c == "-") begin
      sv_state = jsv_pkg::ST_NUM_MINUS;
    end else if (c == "0") begin
      sv_state = jsv_pkg::ST_NUM_ZERO;
    end else if (!is_dig) begin
      sv_ok = 1'b0;
    end
  end

  always_comb begin
    state_d  = state_q;
    eff      = state_q;
    key_d    = key_q;
    sur_d    = sur_q;
    hex_d    = hex_q;
    code_d   = code_q;
    word_d   = word_q;
    lidx_d   = lidx_q;
    ok       = 1'b1;
    consumed = 1'b0;
    ctrl     = '0;

    // number bytes; a byte that ends a number falls through to the next context
    case (state_q)
      jsv_pkg::ST_NUM_MINUS: begin
        consumed = 1'b1;
        if (c == "0") state_d = jsv_pkg::ST_NUM_ZERO;
        else if (is_dig) state_d = jsv_pkg::ST_NUM_INT;
        else ok = 1'b0;
      end
      jsv_pkg::ST_NUM_ZERO, jsv_pkg::ST_NUM_INT: begin
        consumed = 1'b1;
        if (is_dig) ok = (state_q == jsv_pkg::ST_NUM_INT);
        else if (c == ".") state_d = jsv_pkg::ST_NUM_DOT;
        else if ((c == "e") || (c == "E")) state_d = jsv_pkg::ST_NUM_EXP;
        else begin
          consumed = 1'b0;
          eff      = vdone;
        end
      end
      jsv_pkg::ST_NUM_DOT: begin
        consumed = 1'b1;
        if (is_dig) state_d = jsv_pkg::ST_NUM_FRAC;
        else ok = 1'b0;
      end
      jsv_pkg::ST_NUM_FRAC: begin
        consumed = 1'b1;
        if ((c == "e") || (c == "E")) state_d = jsv_pkg::ST_NUM_EXP;
        else if (!is_dig) begin
          consumed = 1'b0;
          eff      = vdone;
        end
      end
      jsv_pkg::ST_NUM_EXP: begin
        consumed = 1'b1;
        if ((c == "+") || (c == "-")) state_d = jsv_pkg::ST_NUM_EXP_SGN;
        else if (is_dig) state_d = jsv_pkg::ST_NUM_EXP_DIG;
        else ok = 1'b0;
      end
      jsv_pkg::ST_NUM_EXP_SGN: begin
        consumed = 1'b1;
        if (is_dig) state_d = jsv_pkg::ST_NUM_EXP_DIG;
        else ok = 1'b0;
      end
      jsv_pkg::ST_NUM_EXP_DIG: begin
        consumed = 1'b1;
        if (!is_dig) begin
          consumed = 1'b0;
          eff      = vdone;
        end
      end
      default: consumed = 1'b0;
    endcase

    if (!consumed) begin
      state_d = eff;
      case (eff)
        jsv_pkg::ST_TOP_VALUE, jsv_pkg::ST_ARR_VALUE, jsv_pkg::ST_OBJ_VALUE,
        jsv_pkg::ST_ARR_FIRST: begin
          if (is_ws) begin
            state_d = eff;
          end else if ((c == "]") && (eff == jsv_pkg::ST_ARR_FIRST)) begin
            ok       = (depth != '0) && (tos == jsv_pkg::KindArr);
            ctrl.pop = 1'b1;
            state_d  = cdone;
          end else begin
            ok        = sv_ok;
            state_d   = sv_state;
            ctrl.push = sv_push;
            ctrl.kind = sv_kind;
            key_d     = 1'b0;
            word_d    = sv_word;
            lidx_d    = 3'd1;
          end
        end
        jsv_pkg::ST_TOP_DONE: ok = is_ws;
        jsv_pkg::ST_OBJ_FIRST, jsv_pkg::ST_OBJ_KEY: begin
          if (is_ws) begin
            state_d = eff;
          end else if ((c == "}") && (eff == jsv_pkg::ST_OBJ_FIRST)) begin
            ok       = (depth != '0) && (tos == jsv_pkg::KindObj);
            ctrl.pop = 1'b1;
            state_d  = cdone;
          end else if (c == "\"") begin
            state_d = jsv_pkg::ST_STR_CHAR;
            key_d   = 1'b1;
          end else begin
            ok = 1'b0;
          end
        end
        jsv_pkg::ST_OBJ_COLON: begin
          if (c == ":") state_d = jsv_pkg::ST_OBJ_VALUE;
          else ok = is_ws;
        end
        jsv_pkg::ST_AFTER_VALUE: begin
          if (is_ws) begin
            state_d = eff;
          end else if (c == ",") begin
            ok      = (depth != '0);
            state_d = (tos == jsv_pkg::KindObj) ? jsv_pkg::ST_OBJ_KEY : jsv_pkg::ST_ARR_VALUE;
          end else if ((c == "]") || (c == "}")) begin
            ok       = (depth != '0) &&
                       (tos == ((c == "}") ? jsv_pkg::KindObj : jsv_pkg::KindArr));
            ctrl.pop = 1'b1;
            state_d  = cdone;
          end else begin
            ok = 1'b0;
          end
        end
        jsv_pkg::ST_STR_CHAR: begin
          if (c == "\"") state_d = key_q ? jsv_pkg::ST_OBJ_COLON : vdone;
          else if (c < 8'h20) ok = 1'b0;
          else if (c == "\\") state_d = jsv_pkg::ST_STR_ESC;
        end
        jsv_pkg::ST_STR_ESC: begin
          if (c == "u") begin
            hex_d   = 3'd0;
            code_d  = 16'd0;
            state_d = jsv_pkg::ST_STR_HEX;
          end else if ((c == "\"") || (c == "\\") || (c == "/") || (c == "b") ||
                       (c == "f") || (c == "n") || (c == "r") || (c == "t")) begin
            state_d = jsv_pkg::ST_STR_CHAR;
          end else begin
            ok = 1'b0;
          end
        end
        jsv_pkg::ST_STR_HEX: begin
          code_d = code_n;
          if (!hex_ok) begin
            ok = 1'b0;
          end else if (hex_q < 3'd3) begin
            hex_d = hex_q + 3'd1;
          end else begin
            hex_d = 3'd0;
            if (sur_q) begin
              // low half of a surrogate pair must follow
              sur_d   = 1'b0;
              ok      = (code_n >= 16'hDC00) && (code_n <= 16'hDFFF);
              state_d = jsv_pkg::ST_STR_CHAR;
            end else if ((code_n >= 16'hD800) && (code_n <= 16'hDBFF)) begin
              sur_d   = 1'b1;
              state_d = jsv_pkg::ST_STR_SUR_BS;
            end else begin
              ok      = !((code_n >= 16'hDC00) && (code_n <= 16'hDFFF));
              state_d = jsv_pkg::ST_STR_CHAR;
            end
          end
        end
        jsv_pkg::ST_STR_SUR_BS: begin
          ok      = (c == "\\");
          state_d = jsv_pkg::ST_STR_SUR_U;
        end
        jsv_pkg::ST_STR_SUR_U: begin
          ok      = (c == "u");
          code_d  = 16'd0;
          state_d = jsv_pkg::ST_STR_HEX;
        end
        jsv_pkg::ST_LITERAL: begin
          ok = (lidx_q < jsv_pkg::lit_len(word_q)) && (c == jsv_pkg::lit_char(word_q, lidx_q));
          lidx_d = lidx_q + 3'd1;
          if (lidx_d == jsv_pkg::lit_len(word_q)) state_d = vdone;
        end
        default: ok = 1'b0;
      endcase
    end

    if (failed_q || !ok) begin
      ctrl.push = 1'b0;
      ctrl.pop  = 1'b0;
    end
    ctrl.clear = s_axis_tlast_i;
  end

  assign failed_d = failed_q || !ok;
  assign depth_nx = ctrl.push ? depth + DW'(1) : ctrl.pop ? depth - DW'(1) : depth;
  assign done = (state_d == jsv_pkg::ST_TOP_DONE) ||
                ((depth_nx == '0) &&
                 ((state_d == jsv_pkg::ST_NUM_ZERO) || (state_d == jsv_pkg::ST_NUM_INT) ||
                  (state_d == jsv_pkg::ST_NUM_FRAC) || (state_d == jsv_pkg::ST_NUM_EXP_DIG)));
  assign stat = failed_d ? jsv_pkg::StatReject :
                !s_axis_tlast_i ? jsv_pkg::StatBusy :
                done ? jsv_pkg::StatAccept : jsv_pkg::StatReject;

  jsv_stack #(.StackEntries(StackEntries)) u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (in_fire),
    .ctrl_i  (ctrl),
    .tos_o   (tos),
    .depth_o (depth)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jsv_pkg::ST_TOP_VALUE;
      failed_q    <= 1'b0;
      key_q       <= 1'b0;
      sur_q       <= 1'b0;
      hex_q       <= 3'd0;
      code_q      <= 16'd0;
      word_q      <= jsv_pkg::WordTrue;
      lidx_q      <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        if (s_axis_tlast_i) begin
          state_q  <= jsv_pkg::ST_TOP_VALUE;
          failed_q <= 1'b0;
          key_q    <= 1'b0;
          sur_q    <= 1'b0;
          hex_q    <= 3'd0;
          code_q   <= 16'd0;
          word_q   <= jsv_pkg::WordTrue;
          lidx_q   <= 3'd0;
        end else if (!failed_q) begin
          state_q  <= state_d;
          failed_q <= failed_d;
          key_q    <= key_d;
          sur_q    <= sur_d;
          hex_q    <= hex_d;
          code_q   <= code_d;
          word_q   <= word_d;
          lidx_q   <= lidx_d;
        end
      end
      if (in_fire) out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_stat_q <= stat;
      out_nest_q <= 7'(depth_nx);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_nest_q, out_stat_q};

endmodule

// File: hdl/jsv_checker.sv
`include "json_syntax_validator_core_defines.svh"

module jsv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o
);

  `JSV_ASSERT_NEXT(a_held, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o)
  `JSV_ASSERT_NEXT(a_result_follows, s_axis_tvalid_i && s_axis_tready_o, m_axis_tvalid_o)
  `JSV_ASSERT_NOW(a_status_code, m_axis_tvalid_o, m_axis_tdata_o[1:0] != 2'd3)
  `JSV_ASSERT_NOW(a_ready_when_empty, !m_axis_tvalid_o, s_axis_tready_o)

endmodule

bind json_syntax_validator_core jsv_checker u_jsv_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
